// ===== src/ppfd_pkg.sv =====
// shared types and constants of the positional pid with filtered derivative
// no dependencies; imported by every module of the block

package ppfd_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int ACC_WIDTH_DEF  = 48;
  localparam int ACC_CAP        = 60;

  localparam int GAIN_W  = 31;
  localparam int LIM_W   = 46;
  localparam int ALPHA_W = 17;
  localparam int RATE_W  = 9;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 46;

  localparam int OUT_RST_W = 16;
  localparam int WIDE_W    = 64;
  localparam int HALF_W    = 32;
  localparam int PROD_W    = GAIN_W + WIDE_W;
  localparam int SCALE_SH  = 16;

  typedef enum logic [1:0] {
    SH_NONE,
    SH_Q8,
    SH_Q16
  } shift_e;

  typedef struct packed {
    logic [GAIN_W-1:0]  kp;
    logic [GAIN_W-1:0]  ki;
    logic [GAIN_W-1:0]  kd;
    logic [LIM_W-1:0]   ilim;
    logic [ALPHA_W-1:0] da;
    logic [ALPHA_W-1:0] oa;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic [GAIN_W-1:0]  a;
    logic [WIDE_W-1:0]  m;
    shift_e             sh;
    logic               sat;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [WIDE_W-1:0] res;
  } mul_rsp_t;

endpackage

// ===== src/ppfd_cfg.sv =====
// configuration register bank: gains, integral clamp, output limits, filter weights
// depends on ppfd_pkg

module ppfd_cfg import ppfd_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_AW-1:0]     cfg_idx_i,
  input  logic [CFG_DW-1:0]     cfg_wdata_i,
  output cfg_t                  cfg_o,
  output logic signed [((DATA_WIDTH > OUT_RST_W) ? DATA_WIDTH : OUT_RST_W)-1:0] out_max_o,
  output logic signed [((DATA_WIDTH > OUT_RST_W) ? DATA_WIDTH : OUT_RST_W)-1:0] out_min_o
);

  localparam int OLW = (DATA_WIDTH > OUT_RST_W) ? DATA_WIDTH : OUT_RST_W;

  localparam logic [CFG_AW-1:0] REG_KP        = 3'd0;
  localparam logic [CFG_AW-1:0] REG_KI        = 3'd1;
  localparam logic [CFG_AW-1:0] REG_KD        = 3'd2;
  localparam logic [CFG_AW-1:0] REG_ILIM      = 3'd3;
  localparam logic [CFG_AW-1:0] REG_OUT_MAX   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_OUT_MIN   = 3'd5;
  localparam logic [CFG_AW-1:0] REG_DER_ALPHA = 3'd6;
  localparam logic [CFG_AW-1:0] REG_OUT_ALPHA = 3'd7;

  localparam int OUT_MAX_RST = 30000;
  localparam int OUT_MIN_RST = -30000;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;
  localparam logic [ALPHA_W-1:0] DA_RST      = 17'd13107;
  localparam logic [ALPHA_W-1:0] OA_RST      = 17'd52429;

  cfg_t                   cfg_q;
  logic signed [OLW-1:0]  out_max_q;
  logic signed [OLW-1:0]  out_min_q;
  logic [ALPHA_W-1:0]     alpha_w;
  logic signed [OLW-1:0]  lim_w;

  // weights above one act as one
  assign alpha_w = (cfg_wdata_i[ALPHA_W-1:0] > ALPHA_ONE) ? ALPHA_ONE
                                                          : cfg_wdata_i[ALPHA_W-1:0];
  assign lim_w   = OLW'($signed(cfg_wdata_i[DATA_WIDTH-1:0]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp   <= '0;
      cfg_q.ki   <= '0;
      cfg_q.kd   <= '0;
      cfg_q.ilim <= '0;
      cfg_q.da   <= DA_RST;
      cfg_q.oa   <= OA_RST;
      out_max_q  <= OLW'(OUT_MAX_RST);
      out_min_q  <= OLW'(OUT_MIN_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KP:        cfg_q.kp   <= cfg_wdata_i[GAIN_W-1:0];
        REG_KI:        cfg_q.ki   <= cfg_wdata_i[GAIN_W-1:0];
        REG_KD:        cfg_q.kd   <= cfg_wdata_i[GAIN_W-1:0];
        REG_ILIM:      cfg_q.ilim <= cfg_wdata_i[LIM_W-1:0];
        REG_OUT_MAX:   out_max_q  <= lim_w;
        REG_OUT_MIN:   out_min_q  <= lim_w;
        REG_DER_ALPHA: cfg_q.da   <= alpha_w;
        REG_OUT_ALPHA: cfg_q.oa   <= alpha_w;
        default: ;
      endcase
    end
  end

  assign cfg_o     = cfg_q;
  assign out_max_o = out_max_q;
  assign out_min_o = out_min_q;

endmodule

// ===== src/ppfd_mul.sv =====
// shared multiply and round unit: sign(m) * round(a * |m| / 2^s), optional clamp to 2^58
// two passes of one 31x32 multiplier per product; depends on ppfd_pkg

module ppfd_mul import ppfd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_LO   = 2'd1;
  localparam logic [1:0] M_HI   = 2'd2;
  localparam logic [1:0] M_FIN  = 2'd3;

  localparam int PP_W    = GAIN_W + HALF_W;
  localparam int SAT_EXP = 58;
  localparam int Q8_SH   = 8;
  localparam int Q16_SH  = 16;
  localparam logic [WIDE_W-1:0] TERM_SAT = WIDE_W'(1) << SAT_EXP;

  logic [1:0]         st_q;
  logic               done_q;
  logic [GAIN_W-1:0]  a_q;
  logic [WIDE_W-1:0]  mag_q;
  logic               neg_q;
  shift_e             sh_q;
  logic               sat_q;
  logic [PROD_W-1:0]  p_q;
  logic [WIDE_W-1:0]  res_q;

  logic [HALF_W-1:0]  m_half;
  logic [PP_W-1:0]    pp;
  logic [PROD_W-1:0]  half;
  logic [PROD_W-1:0]  shifted;
  logic [WIDE_W-1:0]  mag_out;

  always_comb begin
    m_half = (st_q == M_HI) ? mag_q[WIDE_W-1:HALF_W] : mag_q[HALF_W-1:0];
    pp     = PP_W'(a_q) * PP_W'(m_half);
    case (sh_q)
      SH_Q8: begin
        half    = PROD_W'(1) << (Q8_SH - 1);
        shifted = p_q >> Q8_SH;
      end
      SH_Q16: begin
        half    = PROD_W'(1) << (Q16_SH - 1);
        shifted = p_q >> Q16_SH;
      end
      default: begin
        half    = '0;
        shifted = p_q;
      end
    endcase
    if (sat_q && (shifted > PROD_W'(TERM_SAT))) begin
      mag_out = TERM_SAT;
    end else begin
      mag_out = shifted[WIDE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= M_IDLE;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (st_q)
        M_IDLE: if (req_i.start) st_q <= M_LO;
        M_LO:   st_q <= M_HI;
        M_HI:   st_q <= M_FIN;
        M_FIN: begin
          st_q   <= M_IDLE;
          done_q <= 1'b1;
        end
        default: st_q <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      M_IDLE: begin
        if (req_i.start) begin
          a_q   <= req_i.a;
          neg_q <= req_i.m[WIDE_W-1];
          mag_q <= req_i.m[WIDE_W-1] ? (WIDE_W'(0) - req_i.m) : req_i.m;
          sh_q  <= req_i.sh;
          sat_q <= req_i.sat;
        end
      end
      M_LO:  p_q <= PROD_W'(pp) + half;
      M_HI:  p_q <= p_q + PROD_W'({pp, {HALF_W{1'b0}}});
      M_FIN: res_q <= neg_q ? (WIDE_W'(0) - mag_out) : mag_out;
      default: ;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

// ===== src/positional_pid_filtered_derivative.sv =====
// top level: request sequencer, controller state and output register
// depends on ppfd_pkg, ppfd_cfg, ppfd_mul

// Positional PID with filtered derivative, clamped integral and filtered, saturated
// output. A compute request runs through S_EC to S_OUT before its result is loaded
// into the output register, a clear request through S_CLR; a new request is taken in
// the cycle after that load. The sequence is set by the single shared 31x32
// multiplier: six products per sample, each in two passes, with setup and rounding
// cycles around them. in_stall_o is high while a request is in work and while a
// finished result cannot yet be loaded because the previous one is still stalled. The
// user must write registers through the cfg port only while idle; nothing checks it.

module positional_pid_filtered_derivative import ppfd_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int ACC_WIDTH  = ACC_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_AW-1:0]            cfg_idx_i,
  input  logic [CFG_DW-1:0]            cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         action_i,
  input  logic signed [DATA_WIDTH-1:0] setpoint_i,
  input  logic signed [DATA_WIDTH-1:0] measurement_i,
  input  logic [RATE_W-1:0]            integral_rate_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0] control_out_o
);

  localparam int DW  = DATA_WIDTH;
  localparam int OLW = (DW > OUT_RST_W) ? DW : OUT_RST_W;
  localparam int AE  = (ACC_WIDTH > ACC_CAP) ? ACC_CAP : ACC_WIDTH;
  localparam int EW  = DW + 1;
  localparam int ECW = DW + 2;
  localparam int YW  = WIDE_W - SCALE_SH;

  localparam logic signed [WIDE_W-1:0] ACC_HI =
    $signed((WIDE_W'(1) << (AE - 1)) - WIDE_W'(1));
  localparam logic signed [WIDE_W-1:0] ACC_LO = -ACC_HI;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_EC     = 5'd1;
  localparam logic [4:0] S_CLR    = 5'd2;
  localparam logic [4:0] S_TGT_GO = 5'd3;
  localparam logic [4:0] S_TGT_W  = 5'd4;
  localparam logic [4:0] S_DF_GO  = 5'd5;
  localparam logic [4:0] S_DF_W   = 5'd6;
  localparam logic [4:0] S_INT_GO = 5'd7;
  localparam logic [4:0] S_INT_W  = 5'd8;
  localparam logic [4:0] S_ICLP   = 5'd9;
  localparam logic [4:0] S_P_GO   = 5'd10;
  localparam logic [4:0] S_P_W    = 5'd11;
  localparam logic [4:0] S_I_GO   = 5'd12;
  localparam logic [4:0] S_I_W    = 5'd13;
  localparam logic [4:0] S_D2     = 5'd14;
  localparam logic [4:0] S_O_GO   = 5'd15;
  localparam logic [4:0] S_O_W    = 5'd16;
  localparam logic [4:0] S_OUT    = 5'd17;

  cfg_t                  cfg;
  logic signed [OLW-1:0] out_max;
  logic signed [OLW-1:0] out_min;
  mul_req_t              mul_req;
  mul_rsp_t              mul_rsp;

  logic [4:0]               st_q;
  logic                     out_valid_q;
  logic signed [DW-1:0]     out_q;
  logic signed [EW-1:0]     prev_q;
  logic signed [AE-1:0]     iacc_q;
  logic signed [AE-1:0]     df_q;
  logic signed [OLW-1:0]    last_q;

  logic signed [EW-1:0]     e_q;
  logic signed [ECW-1:0]    ec_q;
  logic [RATE_W-1:0]        rate_q;
  logic signed [WIDE_W-1:0] d_q;
  logic signed [WIDE_W-1:0] u_q;
  logic signed [YW-1:0]     y_q;
  logic signed [AE-1:0]     limp_q;
  logic signed [AE-1:0]     limn_q;

  logic                     accept;
  logic                     out_free;
  logic signed [WIDE_W-1:0] res_s;
  logic signed [WIDE_W-1:0] lim_ext;
  logic signed [WIDE_W-1:0] df_sum;
  logic signed [WIDE_W-1:0] df_next;
  logic signed [WIDE_W-1:0] iacc_next;
  logic signed [WIDE_W-1:0] last_ext;
  logic signed [WIDE_W-1:0] last_sh;
  logic signed [WIDE_W-1:0] last_rnd;
  logic signed [WIDE_W-1:0] y_sum;
  logic signed [YW-1:0]     y_hi;
  logic signed [YW-1:0]     y_cl;

  ppfd_cfg #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .out_max_o   (out_max),
    .out_min_o   (out_min)
  );

  ppfd_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign accept   = in_valid_i && (st_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign res_s    = $signed(mul_rsp.res);

  always_comb begin
    lim_ext  = $signed(WIDE_W'(cfg.ilim));
    df_sum   = WIDE_W'(df_q) + res_s;
    if (df_sum > ACC_HI) begin
      df_next = ACC_HI;
    end else if (df_sum < ACC_LO) begin
      df_next = ACC_LO;
    end else begin
      df_next = df_sum;
    end
    if (d_q > WIDE_W'(limp_q)) begin
      iacc_next = WIDE_W'(limp_q);
    end else if (d_q < WIDE_W'(limn_q)) begin
      iacc_next = WIDE_W'(limn_q);
    end else begin
      iacc_next = d_q;
    end
    last_ext = WIDE_W'(last_q);
    last_sh  = {last_ext[WIDE_W-SCALE_SH-1:0], {SCALE_SH{1'b0}}};
    last_rnd = {last_ext[WIDE_W-SCALE_SH-1:0], 1'b1, {(SCALE_SH-1){1'b0}}};
    y_sum    = res_s + last_rnd;
    y_hi     = (y_q > YW'(out_max)) ? YW'(out_max) : y_q;
    y_cl     = (y_hi < YW'(out_min)) ? YW'(out_min) : y_hi;
  end

  always_comb begin
    mul_req       = '0;
    mul_req.sh    = SH_NONE;
    case (st_q)
      S_TGT_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = cfg.kd;
        mul_req.m     = WIDE_W'(ec_q);
        mul_req.sat   = 1'b1;
      end
      S_DF_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = GAIN_W'(cfg.da);
        mul_req.m     = d_q;
        mul_req.sh    = SH_Q16;
      end
      S_INT_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = GAIN_W'(rate_q);
        mul_req.m     = WIDE_W'(e_q);
        mul_req.sat   = 1'b1;
      end
      S_P_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = cfg.kp;
        mul_req.m     = WIDE_W'(e_q);
        mul_req.sat   = 1'b1;
      end
      S_I_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = cfg.ki;
        mul_req.m     = WIDE_W'(iacc_q);
        mul_req.sh    = SH_Q8;
        mul_req.sat   = 1'b1;
      end
      S_O_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = GAIN_W'(cfg.oa);
        mul_req.m     = d_q;
        mul_req.sh    = SH_Q16;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      out_valid_q <= 1'b0;
      prev_q      <= '0;
      iacc_q      <= '0;
      df_q        <= '0;
      last_q      <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (st_q)
        S_IDLE:   if (accept) st_q <= action_i ? S_CLR : S_EC;
        S_EC:     st_q <= S_TGT_GO;
        S_CLR: begin
          if (out_free) begin
            prev_q      <= '0;
            iacc_q      <= '0;
            df_q        <= '0;
            last_q      <= '0;
            out_valid_q <= 1'b1;
            st_q        <= S_IDLE;
          end
        end
        S_TGT_GO: st_q <= S_TGT_W;
        S_TGT_W:  if (mul_rsp.done) st_q <= S_DF_GO;
        S_DF_GO:  st_q <= S_DF_W;
        S_DF_W: begin
          if (mul_rsp.done) begin
            df_q <= AE'(df_next);
            st_q <= S_INT_GO;
          end
        end
        S_INT_GO: st_q <= S_INT_W;
        S_INT_W:  if (mul_rsp.done) st_q <= S_ICLP;
        S_ICLP: begin
          iacc_q <= AE'(iacc_next);
          st_q   <= S_P_GO;
        end
        S_P_GO:   st_q <= S_P_W;
        S_P_W:    if (mul_rsp.done) st_q <= S_I_GO;
        S_I_GO:   st_q <= S_I_W;
        S_I_W:    if (mul_rsp.done) st_q <= S_D2;
        S_D2:     st_q <= S_O_GO;
        S_O_GO:   st_q <= S_O_W;
        S_O_W:    if (mul_rsp.done) st_q <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            prev_q      <= e_q;
            last_q      <= OLW'(y_cl);
            out_valid_q <= 1'b1;
            st_q        <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        if (accept) begin
          e_q    <= EW'(setpoint_i) - EW'(measurement_i);
          rate_q <= integral_rate_i;
          limp_q <= (lim_ext > ACC_HI) ? AE'(ACC_HI) : AE'(lim_ext);
        end
      end
      S_EC: begin
        ec_q   <= ECW'(e_q) - ECW'(prev_q);
        limn_q <= -limp_q;
      end
      S_CLR:   if (out_free) out_q <= '0;
      S_TGT_W: if (mul_rsp.done) d_q <= res_s - WIDE_W'(df_q);
      S_INT_W: if (mul_rsp.done) d_q <= WIDE_W'(iacc_q) + res_s;
      S_P_W:   if (mul_rsp.done) u_q <= res_s + WIDE_W'(df_q);
      S_I_W:   if (mul_rsp.done) u_q <= u_q + res_s;
      S_D2:    d_q <= u_q - last_sh;
      S_O_W:   if (mul_rsp.done) y_q <= y_sum[WIDE_W-1:SCALE_SH];
      S_OUT:   if (out_free) out_q <= y_cl[DW-1:0];
      default: ;
    endcase
  end

  assign in_stall_o    = (st_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign control_out_o = out_q;

endmodule

// ===== src/ppfd_chk.sv =====
// port-level checker for the positional pid, attached to the top level by bind
// depends on ppfd_pkg and positional_pid_filtered_derivative

module ppfd_chk import ppfd_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         action_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic signed [DATA_WIDTH-1:0] control_out_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(control_out_o))
    else $error("stalled result changed");

  // accepted request blocks the input side
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after request");

  // clear request into an empty output gives zero, loaded from the S_CLR state
  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && action_i && !out_valid_o
      |-> ##2 (out_valid_o && (control_out_o == '0)))
    else $error("clear request did not give zero");

  // a new result only appears at the end of a request in work
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without request in work");

endmodule

bind positional_pid_filtered_derivative ppfd_chk #(
  .DATA_WIDTH (DATA_WIDTH)
) u_ppfd_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .action_i      (action_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .control_out_o (control_out_o)
);

// ===== tb/ppfd_tb_pkg.sv =====
// register and request codes shared by the testbench files
// no dependencies; imported by the checker and the testbench top

package ppfd_tb_pkg;

  typedef enum logic [2:0] {
    REG_KP,
    REG_KI,
    REG_KD,
    REG_ILIM,
    REG_OUT_MAX,
    REG_OUT_MIN,
    REG_DERIV_ALPHA,
    REG_OUT_ALPHA
  } reg_idx_e;

  typedef enum logic {
    ACT_COMPUTE,
    ACT_CLEAR
  } action_e;

  localparam int ALPHA_ONE = 65536;

endpackage

// ===== tb/ppfd_checker.sv =====
// checker for the positional pid: tracks register writes, predicts control_out for
// every accepted request and compares it with every accepted result
// depends on ppfd_pkg and ppfd_tb_pkg

module ppfd_checker import ppfd_pkg::*, ppfd_tb_pkg::*; #(
  parameter int DW = DATA_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_AW-1:0]    cfg_idx_i,
  input  logic [CFG_DW-1:0]    cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic                 action_i,
  input  logic signed [DW-1:0] setpoint_i,
  input  logic signed [DW-1:0] measurement_i,
  input  logic [RATE_W-1:0]    integral_rate_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic signed [DW-1:0] control_out_i,
  output int                   pending_o,
  output int                   fail_count_o
);

  localparam int ACC_EFF = (ACC_WIDTH_DEF > ACC_CAP) ? ACC_CAP : ACC_WIDTH_DEF;
  localparam longint ACC_HI = (64'sd1 <<< (ACC_EFF - 1)) - 64'sd1;
  localparam logic [127:0] TERM_SAT = 128'd1 << 58;
  localparam int MAX_REPORTS = 200;

  logic [GAIN_W-1:0]  kp_gain, ki_gain, kd_gain;
  logic [LIM_W-1:0]   int_limit;
  logic signed [DW-1:0] out_max, out_min;
  logic [ALPHA_W-1:0] deriv_alpha, out_alpha;

  logic signed [DW:0]            prev_err;
  logic signed [ACC_WIDTH_DEF-1:0] integ_acc, deriv_acc;
  logic signed [DW-1:0]          last_out;

  logic signed [DW-1:0] ctrl_expected[$];
  int n_requests, n_results, n_errors;

  assign pending_o    = n_requests - n_results;
  assign fail_count_o = n_errors;

  function automatic longint acc_clamp(longint v);
    if (v > ACC_HI) return ACC_HI;
    if (v < -ACC_HI) return -ACC_HI;
    return v;
  endfunction

  // sign(val) * round(gain * |val| / 2^sh), ties away from zero, saturated
  function automatic longint gain_product(logic [GAIN_W-1:0] gain, longint val, int sh);
    logic [63:0]  mag;
    logic [127:0] prod;
    mag = (val < 0) ? -val : val;
    prod = 128'(gain) * 128'(mag);
    if (sh > 0) prod = prod + (128'd1 << (sh - 1));
    prod = prod >> sh;
    if (prod > TERM_SAT) prod = TERM_SAT;
    return (val < 0) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  // sign(d) * round(alpha * |d| / 65536), ties away from zero
  function automatic longint weighted_step(logic [ALPHA_W-1:0] alpha, longint d);
    logic [63:0]  mag;
    logic [127:0] prod;
    mag = (d < 0) ? -d : d;
    prod = (128'(alpha) * 128'(mag) + 128'd32768) >> 16;
    return (d < 0) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic logic signed [DW-1:0] pid_step(logic act, logic signed [DW-1:0] sp,
                                                    logic signed [DW-1:0] ms,
                                                    logic [RATE_W-1:0] rate);
    longint err, derr, dtarget, acc, lim, u, base, y16, y;
    logic [ALPHA_W-1:0] da, oa;
    if (act == ACT_CLEAR) begin
      prev_err  = '0;
      integ_acc = '0;
      deriv_acc = '0;
      last_out  = '0;
      return '0;
    end
    da = (deriv_alpha > ALPHA_ONE) ? ALPHA_W'(ALPHA_ONE) : deriv_alpha;
    oa = (out_alpha > ALPHA_ONE) ? ALPHA_W'(ALPHA_ONE) : out_alpha;

    err  = longint'(sp) - longint'(ms);
    derr = err - longint'(prev_err);

    dtarget   = gain_product(kd_gain, derr, 0);
    deriv_acc = acc_clamp(longint'(deriv_acc) + weighted_step(da, dtarget - longint'(deriv_acc)));

    lim = longint'(int_limit);
    acc = longint'(integ_acc) + err * longint'(rate);
    if (acc > lim) acc = lim;
    if (acc < -lim) acc = -lim;
    acc = acc_clamp(acc);
    integ_acc = acc;

    u    = gain_product(kp_gain, err, 0) + gain_product(ki_gain, acc, 8) + longint'(deriv_acc);
    base = longint'(last_out) * 65536;
    y16  = base + weighted_step(oa, u - base);
    y    = (y16 + 32768) >>> 16;

    if (y > longint'(out_max)) y = longint'(out_max);
    if (y < longint'(out_min)) y = longint'(out_min);

    prev_err = err;
    last_out = y;
    return y;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [DW-1:0] exp_val;
    if (!rst_ni) begin
      kp_gain     = '0;
      ki_gain     = '0;
      kd_gain     = '0;
      int_limit   = '0;
      out_max     = 30000;
      out_min     = -30000;
      deriv_alpha = 13107;
      out_alpha   = 52429;
      prev_err    = '0;
      integ_acc   = '0;
      deriv_acc   = '0;
      last_out    = '0;
      ctrl_expected.delete();
      n_requests <= 0;
      n_results  <= 0;
      n_errors   <= 0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_KP:          kp_gain     = cfg_wdata_i[GAIN_W-1:0];
          REG_KI:          ki_gain     = cfg_wdata_i[GAIN_W-1:0];
          REG_KD:          kd_gain     = cfg_wdata_i[GAIN_W-1:0];
          REG_ILIM:        int_limit   = cfg_wdata_i[LIM_W-1:0];
          REG_OUT_MAX:     out_max     = cfg_wdata_i[DW-1:0];
          REG_OUT_MIN:     out_min     = cfg_wdata_i[DW-1:0];
          REG_DERIV_ALPHA: deriv_alpha = cfg_wdata_i[ALPHA_W-1:0];
          REG_OUT_ALPHA:   out_alpha   = cfg_wdata_i[ALPHA_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        if (ctrl_expected.size() == 0) begin
          if (n_errors < MAX_REPORTS)
            $display("%0t: control_out expected none, got %0d", $time, control_out_i);
          n_errors <= n_errors + 1;
        end else begin
          exp_val = ctrl_expected.pop_front();
          n_results <= n_results + 1;
          if (control_out_i !== exp_val) begin
            if (n_errors < MAX_REPORTS)
              $display("%0t: control_out expected %0d, got %0d", $time, exp_val,
                       control_out_i);
            n_errors <= n_errors + 1;
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        ctrl_expected.push_back(pid_step(action_i, setpoint_i, measurement_i,
                                         integral_rate_i));
        n_requests <= n_requests + 1;
      end
    end
  end

endmodule

// ===== tb/testbench.sv =====
// testbench top: clock, reset, register settings, request and stall stimulus, verdict
// depends on ppfd_pkg, ppfd_tb_pkg, ppfd_checker and positional_pid_filtered_derivative

module testbench;
  import ppfd_pkg::*;
  import ppfd_tb_pkg::*;

  localparam int DW = DATA_WIDTH_DEF;
  localparam int RANDOM_ITEMS = 1700;
  localparam logic [GAIN_W-1:0] MAX_GAIN = '1;
  localparam logic [LIM_W-1:0]  MAX_ILIM = '1;

  logic                 clk, rst_n;
  logic                 cfg_we;
  logic [CFG_AW-1:0]    cfg_idx;
  logic [CFG_DW-1:0]    cfg_wdata;
  logic                 in_valid, in_stall, in_action;
  logic signed [DW-1:0] setpoint, measurement;
  logic [RATE_W-1:0]    rate;
  logic                 out_valid, out_stall;
  logic signed [DW-1:0] control_out;
  int                   pending, fails;
  logic                 steady;

  positional_pid_filtered_derivative i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .action_i        (in_action),
    .setpoint_i      (setpoint),
    .measurement_i   (measurement),
    .integral_rate_i (rate),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .control_out_o   (control_out)
  );

  ppfd_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .action_i        (in_action),
    .setpoint_i      (setpoint),
    .measurement_i   (measurement),
    .integral_rate_i (rate),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .control_out_i   (control_out),
    .pending_o       (pending),
    .fail_count_o    (fails)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [DW-1:0] sat_word(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic logic signed [DW-1:0] extreme_word();
    case ($urandom_range(0, 6))
      0:       return -32768;
      1:       return -32767;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      5:       return 32766;
      default: return 32767;
    endcase
  endfunction

  function automatic logic [RATE_W-1:0] pick_rate();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return 0;
    if (r < 27) return 256;
    return $urandom_range(0, 256);
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return MAX_GAIN;
      2, 3:    return GAIN_W'($urandom);
      default: return $urandom_range(0, 1 << 18);
    endcase
  endfunction

  function automatic logic [ALPHA_W-1:0] pick_alpha();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ALPHA_ONE;
      2:       return $urandom_range(ALPHA_ONE + 1, 131071);
      default: return $urandom_range(1, ALPHA_ONE);
    endcase
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [CFG_DW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic apply_setting(logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] ki,
                               logic [GAIN_W-1:0] kd, logic [LIM_W-1:0] ilim,
                               logic signed [DW-1:0] omax, logic signed [DW-1:0] omin,
                               logic [ALPHA_W-1:0] da, logic [ALPHA_W-1:0] oa);
    write_reg(REG_KP, CFG_DW'(kp));
    write_reg(REG_KI, CFG_DW'(ki));
    write_reg(REG_KD, CFG_DW'(kd));
    write_reg(REG_ILIM, CFG_DW'(ilim));
    write_reg(REG_OUT_MAX, CFG_DW'(unsigned'(omax)));
    write_reg(REG_OUT_MIN, CFG_DW'(unsigned'(omin)));
    write_reg(REG_DERIV_ALPHA, CFG_DW'(da));
    write_reg(REG_OUT_ALPHA, CFG_DW'(oa));
    cfg_we <= 1'b0;
  endtask

  task automatic issue(logic act, logic signed [DW-1:0] sp, logic signed [DW-1:0] ms,
                       logic [RATE_W-1:0] r);
    int gap;
    in_valid    <= 1'b1;
    in_action   <= act;
    setpoint    <= sp;
    measurement <= ms;
    rate        <= r;
    do @(posedge clk); while (in_stall);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int sent, n, pick, base_sp;
    logic [GAIN_W-1:0]    kp, ki, kd;
    logic [LIM_W-1:0]     ilim;
    logic signed [DW-1:0] omax, omin, a, b;
    logic [ALPHA_W-1:0]   da, oa;

    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_idx     <= '0;
    cfg_wdata   <= '0;
    in_valid    <= 1'b0;
    in_action   <= ACT_COMPUTE;
    setpoint    <= '0;
    measurement <= '0;
    rate        <= '0;
    steady      <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register values after reset
    issue(ACT_COMPUTE, 32767, -32768, 256);
    issue(ACT_CLEAR, 0, 0, 0);
    wait_idle();
    write_reg(REG_KP, CFG_DW'(3 << 16));
    cfg_we <= 1'b0;
    issue(ACT_COMPUTE, 32767, -32768, 256);
    issue(ACT_COMPUTE, -32768, 32767, 0);
    issue(ACT_COMPUTE, 0, 0, 128);

    // unity filters, full output range
    wait_idle();
    apply_setting(1 << 16, 1 << 14, 1 << 15, 1 << 20, 32767, -32768, ALPHA_ONE, ALPHA_ONE);
    issue(ACT_CLEAR, 0, 0, 0);
    issue(ACT_COMPUTE, 100, 90, 1);
    issue(ACT_COMPUTE, -1, 0, 255);
    issue(ACT_COMPUTE, 12000, -3000, 256);
    issue(ACT_COMPUTE, 5, 5, 0);
    issue(ACT_CLEAR, 32767, -32768, 256);
    issue(ACT_COMPUTE, -20000, 20000, 200);

    // maximum gains and limit, crossed output limits, filter weights above one
    wait_idle();
    apply_setting(MAX_GAIN, MAX_GAIN, MAX_GAIN, MAX_ILIM, -100, 100, 131071, ALPHA_ONE + 1);
    issue(ACT_COMPUTE, 32767, -32768, 256);
    issue(ACT_COMPUTE, 32767, -32768, 256);
    issue(ACT_COMPUTE, -32768, 32767, 256);
    issue(ACT_COMPUTE, 0, 0, 0);
    issue(ACT_CLEAR, -32768, 32767, 0);

    // zero filter weights and zero integral limit
    wait_idle();
    apply_setting(1 << 12, 1 << 10, 1 << 16, 0, 500, -500, 0, 0);
    issue(ACT_COMPUTE, 300, 0, 256);
    issue(ACT_COMPUTE, -300, 0, 256);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      steady <= ($urandom_range(0, 3) == 0);
      kp = pick_gain();
      ki = pick_gain();
      kd = pick_gain();
      case ($urandom_range(0, 5))
        0:       ilim = '0;
        1:       ilim = MAX_ILIM;
        2:       ilim = LIM_W'({$urandom, $urandom});
        default: ilim = $urandom_range(0, 1 << 22);
      endcase
      a = DW'($urandom);
      b = DW'($urandom);
      case ($urandom_range(0, 5))
        0: begin
          omax = (a < b) ? a : b;
          omin = (a < b) ? b : a;
        end
        1: begin
          omax = 32767;
          omin = -32768;
        end
        2: begin
          omax = (a < b) ? b : a;
          omin = (a < b) ? a : b;
        end
        default: begin
          omax = $urandom_range(0, 32767);
          omin = -int'($urandom_range(0, 32768));
        end
      endcase
      da = pick_alpha();
      oa = pick_alpha();
      apply_setting(kp, ki, kd, ilim, omax, omin, da, oa);

      n = $urandom_range(20, 120);
      base_sp = int'($urandom_range(0, 8000)) - 4000;
      repeat (n) begin
        pick = $urandom_range(0, 99);
        if (pick < 4)
          issue(ACT_CLEAR, DW'($urandom), DW'($urandom), $urandom_range(0, 256));
        else if (pick < 55)
          issue(ACT_COMPUTE, sat_word(base_sp + int'($urandom_range(0, 600)) - 300),
                sat_word(base_sp + int'($urandom_range(0, 600)) - 300), pick_rate());
        else if (pick < 85)
          issue(ACT_COMPUTE, DW'($urandom), DW'($urandom), pick_rate());
        else
          issue(ACT_COMPUTE, extreme_word(), extreme_word(), pick_rate());
      end
      sent += n;
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (fails == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    int hold;
    out_stall <= 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      hold = pick_gap();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

endmodule

// ===== positional_pid_filtered_derivative.f =====
src/ppfd_pkg.sv
src/ppfd_cfg.sv
src/ppfd_mul.sv
src/positional_pid_filtered_derivative.sv
src/ppfd_chk.sv
tb/ppfd_tb_pkg.sv
tb/ppfd_checker.sv
tb/testbench.sv
